// ----- hdl/sdnc_pkg.sv -----
`timescale 1ns / 1ps
package sdnc_pkg;

   // lane width covers the widest scaled normal plus cordic growth
   localparam int LANE_W     = 42;
   localparam int ZW         = 26;
   localparam int SQ_W       = 63;
   localparam int SQRT_CELLS = 31;
   localparam int SUB_BITS   = 9;

   localparam logic [15:0] ANG_FULL    = 16'd46080;
   localparam logic [15:0] ANG_QUARTER = 16'd11520;
   localparam logic [15:0] ANG_HALF    = 16'd23040;
   localparam logic [15:0] ANG_3QUART  = 16'd34560;

   localparam logic signed [LANE_W-1:0] GAIN_X4     = 42'sd2608131496;
   localparam logic signed [ZW-1:0]     Z_HALF_TURN = 26'sd11796480;

   // atan(2^-i) in 2^-16 degree
   localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
      26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
      26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
      26'sd917,     26'sd458,     26'sd229,    26'sd115,
      26'sd57,      26'sd29,      26'sd14,     26'sd7,
      26'sd4,       26'sd2,       26'sd1,      26'sd0,
      26'sd0,       26'sd0,       26'sd0,      26'sd0,
      26'sd0,       26'sd0,       26'sd0,      26'sd0
   };

   typedef struct packed {
      logic              func;
      logic signed [15:0] normal_x_in;
      logic signed [15:0] normal_y_in;
      logic signed [15:0] normal_z_in;
      logic [15:0]       strike_in;
      logic [14:0]       dip_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] dip_vec_x;
      logic signed [15:0] dip_vec_y;
      logic signed [15:0] dip_vec_z;
      logic signed [15:0] strike_vec_x;
      logic signed [15:0] strike_vec_y;
      logic signed [15:0] strike_vec_z;
      logic signed [15:0] normal_x_out;
      logic signed [15:0] normal_y_out;
      logic signed [15:0] normal_z_out;
      logic [15:0]       strike_out;
      logic [14:0]       dip_out;
   } rsp_type;

   // per-item control that rides along the cell chain
   typedef struct packed {
      logic        func;
      logic [1:0]  quad_s;
      logic [1:0]  quad_d;
      logic        rzero_s;
      logic        rzero_d;
      logic        flat_zero;
      logic [15:0] strike;
      logic [14:0] dip;
      logic [15:0] nx;
      logic [15:0] ny;
      logic [15:0] nz;
   } side_type;

   typedef struct packed {
      logic signed [LANE_W-1:0] x;
      logic signed [LANE_W-1:0] y;
      logic signed [ZW-1:0]     z;
   } lane_type;

   // round to nearest, ties away from zero
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int s);
      logic signed [63:0] h;
      logic signed [63:0] a;
      logic signed [63:0] r;
      if (s == 0) begin
         r = v;
      end else begin
         h = 64'sd1 <<< (s - 1);
         if (v >= 0) begin
            r = (v + h) >>> s;
         end else begin
            a = -v;
            r = -((a + h) >>> s);
         end
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v < -64'sd32768) begin
         r = 16'sh8000;
      end else if (v > 64'sd32767) begin
         r = 16'sh7fff;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/sdnc_if.sv -----
`timescale 1ns / 1ps
interface sdnc_req_if;
   import sdnc_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sdnc_rsp_if;
   import sdnc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/sdnc_sqrt_cell.sv -----
`timescale 1ns / 1ps
module sdnc_sqrt_cell #(
   parameter int STAGE = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  sdnc_pkg::side_type           in_side,
   input  sdnc_pkg::lane_type           in_a,
   input  sdnc_pkg::lane_type           in_b,
   input  logic [sdnc_pkg::SQ_W-1:0]    in_rem,
   input  logic [sdnc_pkg::SQ_W-1:0]    in_root,
   output logic                         out_valid,
   output sdnc_pkg::side_type           out_side,
   output sdnc_pkg::lane_type           out_a,
   output sdnc_pkg::lane_type           out_b,
   output logic [sdnc_pkg::SQ_W-1:0]    out_rem,
   output logic [sdnc_pkg::SQ_W-1:0]    out_root
);
   import sdnc_pkg::*;

   // one result bit per cell, weight 4^(30-STAGE)
   localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << (60 - 2 * STAGE);

   logic            valid_ff;
   side_type        side_ff;
   lane_type        a_ff, b_ff;
   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] root_ff, root_in;
   logic [SQ_W-1:0] trial;

   always_comb begin
      trial = in_root + BIT;
      if (in_rem >= trial) begin
         rem_in  = in_rem - trial;
         root_in = (in_root >> 1) + BIT;
      end else begin
         rem_in  = in_rem;
         root_in = in_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         a_ff    <= in_a;
         b_ff    <= in_b;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

// ----- hdl/sdnc_cordic_cell.sv -----
`timescale 1ns / 1ps
module sdnc_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  sdnc_pkg::side_type in_side,
   input  sdnc_pkg::lane_type in_a,
   input  sdnc_pkg::lane_type in_b,
   output logic               out_valid,
   output sdnc_pkg::side_type out_side,
   output sdnc_pkg::lane_type out_a,
   output sdnc_pkg::lane_type out_b
);
   import sdnc_pkg::*;

   // rotation drives z to zero, vectoring drives y to zero
   function automatic lane_type lane_step(input lane_type l, input logic rot);
      logic signed [LANE_W-1:0] x, y, dx, dy;
      logic signed [ZW-1:0]     z;
      logic                     sigma;
      lane_type                 r;
      x     = l.x;
      y     = l.y;
      z     = l.z;
      dx    = x >>> STEP;
      dy    = y >>> STEP;
      sigma = rot ? ~z[ZW-1] : y[LANE_W-1];
      if (sigma) begin
         r.x = x - dy;
         r.y = y + dx;
         r.z = z - ATAN_TAB[STEP];
      end else begin
         r.x = x + dy;
         r.y = y - dx;
         r.z = z + ATAN_TAB[STEP];
      end
      return r;
   endfunction

   logic     valid_ff;
   side_type side_ff;
   lane_type a_ff, a_in;
   lane_type b_ff, b_in;

   assign a_in = lane_step(in_a, ~in_side.func);
   assign b_in = lane_step(in_b, ~in_side.func);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         a_ff    <= a_in;
         b_ff    <= b_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;

endmodule

// ----- hdl/strike_dip_normal_conversion_unit.sv -----
`timescale 1ns / 1ps
// channel  | direction | payload
// req_if   | in        | func, strike/dip angles, normal vector
// rsp_if   | out       | dip, strike and normal vectors, strike and dip angles
//
// one item enters per cycle unless a result is held at the output; each result passes through
// the input register, the 31 square-root cells, the CORDIC_STEPS cordic cells and post stages 1 to 3
// reset is synchronous and clears the valid bits of every stage
// a result held at the output stalls the whole chain, and req_if.ready drops with it
module strike_dip_normal_conversion_unit #(
   parameter int VEC_FRAC_BITS = 14,
   parameter int CORDIC_STEPS  = 16
) (
   input logic        clock,
   input logic        reset,
   sdnc_req_if.sink   req_if,
   sdnc_rsp_if.source rsp_if
);
   import sdnc_pkg::*;

   localparam int S30 = 30 - VEC_FRAC_BITS;
   localparam int S60 = 60 - VEC_FRAC_BITS;
   localparam logic signed [31:0] ONE_VEC = 32'sd1 <<< VEC_FRAC_BITS;
   localparam logic signed [63:0] ONE30   = 64'sd1 <<< 30;

   typedef struct packed {
      logic [1:0]  quad;
      logic [13:0] rem;
   } split_type;

   typedef struct packed {
      logic signed [31:0] c;
      logic signed [31:0] s;
   } trig_type;

   // reduce modulo a full turn and split into quadrant and remainder
   function automatic split_type angle_split(input logic [15:0] ang);
      logic [15:0] a;
      split_type   r;
      a = (ang >= ANG_FULL) ? ang - ANG_FULL : ang;
      if (a < ANG_QUARTER) begin
         r.quad = 2'd0;
         r.rem  = a[13:0];
      end else if (a < ANG_HALF) begin
         r.quad = 2'd1;
         r.rem  = 14'(a - ANG_QUARTER);
      end else if (a < ANG_3QUART) begin
         r.quad = 2'd2;
         r.rem  = 14'(a - ANG_HALF);
      end else begin
         r.quad = 2'd3;
         r.rem  = 14'(a - ANG_3QUART);
      end
      return r;
   endfunction

   function automatic logic signed [31:0] clamp30(input logic signed [63:0] v);
      logic signed [63:0] r;
      if (v > ONE30) begin
         r = ONE30;
      end else if (v < -ONE30) begin
         r = -ONE30;
      end else begin
         r = v;
      end
      return r[31:0];
   endfunction

   // cordic lanes to cos/sin, then unfold the quadrant
   function automatic trig_type to_trig(input lane_type l, input logic rz, input logic [1:0] q);
      logic signed [31:0] cc, ss;
      trig_type           r;
      if (rz) begin
         cc = ONE30[31:0];
         ss = 32'sd0;
      end else begin
         cc = clamp30(rnd_shift({{(64-LANE_W){l.x[LANE_W-1]}}, l.x}, 2));
         ss = clamp30(rnd_shift({{(64-LANE_W){l.y[LANE_W-1]}}, l.y}, 2));
      end
      case (q)
         2'd0: begin
            r.c = cc;
            r.s = ss;
         end
         2'd1: begin
            r.c = -ss;
            r.s = cc;
         end
         2'd2: begin
            r.c = -cc;
            r.s = -ss;
         end
         default: begin
            r.c = ss;
            r.s = -cc;
         end
      endcase
      return r;
   endfunction

   // whole chain advances together; output register holds a stalled result
   logic en;
   logic out_valid_ff;
   logic out_func_ff;
   rsp_type out_ff, out_in;

   assign en           = ~out_valid_ff | rsp_if.ready;
   assign req_if.ready = en;

   // ---------------- input preparation ----------------
   req_type                  rq;
   split_type                sp_s, sp_d;
   side_type                 side_in;
   lane_type                 a_in, b_in;
   logic signed [LANE_W-1:0] nxw, nyw, nzw;
   logic signed [31:0]       nz32;
   logic signed [16:0]       nz_clamp;
   logic signed [33:0]       nz_sq;
   logic [SQ_W-1:0]          rem0_in;

   assign rq   = req_if.payload;
   assign sp_s = angle_split(rq.strike_in);
   assign sp_d = angle_split({1'b0, rq.dip_in});

   always_comb begin
      nz32 = {{16{rq.normal_z_in[15]}}, rq.normal_z_in};
      if (nz32 > ONE_VEC) begin
         nz_clamp = ONE_VEC[16:0];
      end else if (nz32 < -ONE_VEC) begin
         nz_clamp = 17'(-ONE_VEC);
      end else begin
         nz_clamp = nz32[16:0];
      end
      nz_sq   = nz_clamp * nz_clamp;
      // 1 - nz^2 at 60 fraction bits
      rem0_in = (SQ_W'(1) << 60) - (SQ_W'(nz_sq) << (60 - 2 * VEC_FRAC_BITS));

      nxw = {{(LANE_W-16){rq.normal_x_in[15]}}, rq.normal_x_in} <<< S30;
      nyw = {{(LANE_W-16){rq.normal_y_in[15]}}, rq.normal_y_in} <<< S30;
      nzw = {{(LANE_W-17){nz_clamp[16]}}, nz_clamp} <<< S30;

      side_in.func      = rq.func;
      side_in.quad_s    = sp_s.quad;
      side_in.quad_d    = sp_d.quad;
      side_in.rzero_s   = (sp_s.rem == 14'd0);
      side_in.rzero_d   = (sp_d.rem == 14'd0);
      side_in.flat_zero = (rq.normal_x_in == 16'sd0) && (rq.normal_y_in == 16'sd0);
      side_in.strike    = rq.strike_in;
      side_in.dip       = rq.dip_in;
      side_in.nx        = rq.normal_x_in;
      side_in.ny        = rq.normal_y_in;
      side_in.nz        = rq.normal_z_in;

      if (!rq.func) begin
         // rotation lanes: strike in a, dip in b
         a_in.x = GAIN_X4;
         a_in.y = '0;
         a_in.z = ZW'(sp_s.rem) <<< SUB_BITS;
         b_in.x = GAIN_X4;
         b_in.y = '0;
         b_in.z = ZW'(sp_d.rem) <<< SUB_BITS;
      end else begin
         // vectoring lanes: (hz, nz) in a once the root is known, (nx, ny) in b
         a_in.x = '0;
         a_in.y = nzw;
         a_in.z = '0;
         if (nxw < 0) begin
            b_in.x = -nxw;
            b_in.y = -nyw;
            b_in.z = Z_HALF_TURN;
         end else begin
            b_in.x = nxw;
            b_in.y = nyw;
            b_in.z = '0;
         end
      end
   end

   logic            pre_valid_ff;
   side_type        pre_side_ff;
   lane_type        pre_a_ff, pre_b_ff;
   logic [SQ_W-1:0] pre_rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (en) begin
         pre_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_side_ff <= side_in;
         pre_a_ff    <= a_in;
         pre_b_ff    <= b_in;
         pre_rem_ff  <= rem0_in;
      end
   end

   // ---------------- square-root cells ----------------
   logic            sq_valid [SQRT_CELLS+1];
   side_type        sq_side  [SQRT_CELLS+1];
   lane_type        sq_a     [SQRT_CELLS+1];
   lane_type        sq_b     [SQRT_CELLS+1];
   logic [SQ_W-1:0] sq_rem   [SQRT_CELLS+1];
   logic [SQ_W-1:0] sq_root  [SQRT_CELLS+1];

   assign sq_valid[0] = pre_valid_ff;
   assign sq_side[0]  = pre_side_ff;
   assign sq_a[0]     = pre_a_ff;
   assign sq_b[0]     = pre_b_ff;
   assign sq_rem[0]   = pre_rem_ff;
   assign sq_root[0]  = '0;

   for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
      sdnc_sqrt_cell #(.STAGE(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_valid[k]),
         .in_side   (sq_side[k]),
         .in_a      (sq_a[k]),
         .in_b      (sq_b[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .out_valid (sq_valid[k+1]),
         .out_side  (sq_side[k+1]),
         .out_a     (sq_a[k+1]),
         .out_b     (sq_b[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1])
      );
   end

   // ---------------- cordic cells ----------------
   logic     co_valid [CORDIC_STEPS+1];
   side_type co_side  [CORDIC_STEPS+1];
   lane_type co_a     [CORDIC_STEPS+1];
   lane_type co_b     [CORDIC_STEPS+1];
   lane_type co_dip_lane;

   // horizontal length of the normal enters the dip lane as x
   always_comb begin
      co_dip_lane = sq_a[SQRT_CELLS];
      if (sq_side[SQRT_CELLS].func) begin
         co_dip_lane.x = sq_root[SQRT_CELLS][LANE_W-1:0];
      end
   end
   assign co_a[0]     = co_dip_lane;
   assign co_valid[0] = sq_valid[SQRT_CELLS];
   assign co_side[0]  = sq_side[SQRT_CELLS];
   assign co_b[0]     = sq_b[SQRT_CELLS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      sdnc_cordic_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (co_valid[i]),
         .in_side   (co_side[i]),
         .in_a      (co_a[i]),
         .in_b      (co_b[i]),
         .out_valid (co_valid[i+1]),
         .out_side  (co_side[i+1]),
         .out_a     (co_a[i+1]),
         .out_b     (co_b[i+1])
      );
   end

   // ---------------- post stage 1: trig values and angles ----------------
   side_type           lst_side;
   lane_type           lst_a, lst_b;
   trig_type           trig_s, trig_d;
   logic signed [63:0] dip_z, dd_z;
   logic [14:0]        dip_ang_in;
   logic [15:0]        strike_ang_in;

   assign lst_side = co_side[CORDIC_STEPS];
   assign lst_a    = co_a[CORDIC_STEPS];
   assign lst_b    = co_b[CORDIC_STEPS];
   assign trig_s   = to_trig(lst_a, lst_side.rzero_s, lst_side.quad_s);
   assign trig_d   = to_trig(lst_b, lst_side.rzero_d, lst_side.quad_d);

   always_comb begin
      dip_z = rnd_shift({{(64-ZW){lst_a.z[ZW-1]}}, lst_a.z}, SUB_BITS);
      if (dip_z < 0) begin
         dip_ang_in = '0;
      end else if (dip_z > 64'(ANG_HALF)) begin
         dip_ang_in = ANG_HALF[14:0];
      end else begin
         dip_ang_in = dip_z[14:0];
      end
      // zero horizontal normal gives dip direction zero
      if (lst_side.flat_zero) begin
         dd_z = '0;
      end else begin
         dd_z = rnd_shift({{(64-ZW){lst_b.z[ZW-1]}}, lst_b.z}, SUB_BITS);
      end
      if (dd_z < 0) begin
         dd_z = dd_z + 64'(ANG_FULL);
      end
      strike_ang_in = ANG_FULL - dd_z[15:0];
   end

   logic               p1_valid_ff;
   side_type           p1_side_ff;
   trig_type           p1_s_ff, p1_d_ff;
   logic [14:0]        p1_dip_ff;
   logic [15:0]        p1_strike_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= co_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_side_ff   <= lst_side;
         p1_s_ff      <= trig_s;
         p1_d_ff      <= trig_d;
         p1_dip_ff    <= dip_ang_in;
         p1_strike_ff <= strike_ang_in;
      end
   end

   // ---------------- post stage 2: products and single-term outputs ----------------
   logic signed [31:0] cs, ss, cd, sd;
   logic               g_neg_in;
   logic signed [63:0] p_cc_in, p_sc_in, p_dc_in, p_ds_in;
   logic signed [63:0] r_sd, r_ss, r_cs, r_cd;
   logic signed [15:0] dvz_in, svx_in, svy_in, nzo_in;

   assign cs = p1_s_ff.c;
   assign ss = p1_s_ff.s;
   assign cd = p1_d_ff.c;
   assign sd = p1_d_ff.s;

   // vertical plane (cos d exactly zero) keeps the positive sign
   assign g_neg_in = cd < 0;

   always_comb begin
      p_cc_in = cs * cd;
      p_sc_in = ss * cd;
      p_dc_in = sd * cs;
      p_ds_in = sd * ss;
      r_sd    = rnd_shift(64'(sd), S30);
      r_ss    = rnd_shift(64'(ss), S30);
      r_cs    = rnd_shift(64'(cs), S30);
      r_cd    = rnd_shift(64'(cd), S30);
      dvz_in  = sat16(-r_sd);
      svx_in  = sat16(g_neg_in ? -r_ss : r_ss);
      svy_in  = sat16(g_neg_in ? -r_cs : r_cs);
      nzo_in  = sat16(g_neg_in ? -r_cd : r_cd);
   end

   logic               p2_valid_ff;
   side_type           p2_side_ff;
   logic               p2_g_neg_ff;
   logic signed [63:0] p2_cc_ff, p2_sc_ff, p2_dc_ff, p2_ds_ff;
   logic signed [15:0] p2_dvz_ff, p2_svx_ff, p2_svy_ff, p2_nzo_ff;
   logic [14:0]        p2_dip_ff;
   logic [15:0]        p2_strike_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_side_ff   <= p1_side_ff;
         p2_g_neg_ff  <= g_neg_in;
         p2_cc_ff     <= p_cc_in;
         p2_sc_ff     <= p_sc_in;
         p2_dc_ff     <= p_dc_in;
         p2_ds_ff     <= p_ds_in;
         p2_dvz_ff    <= dvz_in;
         p2_svx_ff    <= svx_in;
         p2_svy_ff    <= svy_in;
         p2_nzo_ff    <= nzo_in;
         p2_dip_ff    <= p1_dip_ff;
         p2_strike_ff <= p1_strike_ff;
      end
   end

   // ---------------- post stage 3: product rounding and result assembly ----------------
   logic signed [63:0] r_cc, r_sc, r_dc, r_ds;

   always_comb begin
      r_cc = rnd_shift(p2_cc_ff, S60);
      r_sc = rnd_shift(p2_sc_ff, S60);
      r_dc = rnd_shift(p2_dc_ff, S60);
      r_ds = rnd_shift(p2_ds_ff, S60);
      if (!p2_side_ff.func) begin
         out_in.dip_vec_x    = sat16(r_cc);
         out_in.dip_vec_y    = sat16(-r_sc);
         out_in.dip_vec_z    = p2_dvz_ff;
         out_in.strike_vec_x = p2_svx_ff;
         out_in.strike_vec_y = p2_svy_ff;
         out_in.strike_vec_z = '0;
         out_in.normal_x_out = sat16(p2_g_neg_ff ? -r_dc : r_dc);
         out_in.normal_y_out = sat16(p2_g_neg_ff ? r_ds : -r_ds);
         out_in.normal_z_out = p2_nzo_ff;
         out_in.strike_out   = p2_side_ff.strike;
         out_in.dip_out      = p2_side_ff.dip;
      end else begin
         out_in.dip_vec_x    = '0;
         out_in.dip_vec_y    = '0;
         out_in.dip_vec_z    = '0;
         out_in.strike_vec_x = '0;
         out_in.strike_vec_y = '0;
         out_in.strike_vec_z = '0;
         out_in.normal_x_out = p2_side_ff.nx;
         out_in.normal_y_out = p2_side_ff.ny;
         out_in.normal_z_out = p2_side_ff.nz;
         out_in.strike_out   = p2_strike_ff;
         out_in.dip_out      = p2_dip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff      <= out_in;
         out_func_ff <= p2_side_ff.func;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_ff;

`ifndef NO_ASSERTIONS
   // a held result must stop intake
   a_stall_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> !req_if.ready)
      else $error("item accepted while result stalled");

   // normal-to-angle results stay within their angle ranges
   a_mode1_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_func_ff) |->
      (out_ff.strike_out != 16'd0 && out_ff.strike_out <= ANG_FULL &&
       out_ff.dip_out <= ANG_HALF[14:0]))
      else $error("angle result out of range");

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_if.valid)
      else $error("result valid after reset");
`endif

endmodule

// ----- tb/strike_dip_normal_conversion_unit_test.sv -----
`timescale 1ns / 1ps
module strike_dip_normal_conversion_unit_test;
   import sdnc_pkg::*;

   localparam int FRAC      = 14;
   localparam int STEPS     = 16;
   localparam int LATENCY   = STEPS + 35;
   localparam int FUNC_VEC  = 0;   // angles to vectors
   localparam int FUNC_ANG  = 1;   // normal to angles
   localparam longint ONE30 = 64'sd1 << 30;
   localparam longint GAIN  = 64'sd652032874;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   rsp_long_stall;   // percent of long stalls on the result side
   int   rsp_hold;         // cycles left in the current long stall
   bit   stall_free;       // stretches with no idling at all

   sdnc_req_if req_if ();
   sdnc_rsp_if rsp_if ();

   rsp_type expected_orient_q[$];

   strike_dip_normal_conversion_unit #(
      .VEC_FRAC_BITS(FRAC),
      .CORDIC_STEPS (STEPS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // arctangent table in 2^-16 degree
   function automatic longint atan_step(input int i);
      longint tab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
      return (i < 24) ? tab[i] : 0;
   endfunction

   function automatic longint round_shift(input longint v, input int s);
      longint h;
      h = 64'sd1 <<< (s - 1);
      return (v >= 0) ? ((v + h) >>> s) : -((-v + h) >>> s);
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic signed [15:0] saturate(input longint v);
      return 16'(clamp(v, -32768, 32767));
   endfunction

   // rotation cordic: cos and sin at 30 fraction bits of an angle in 1/128 degree
   function automatic void rotate_angle(input int unsigned ang, output longint c,
                                        output longint s);
      int unsigned a, q, r;
      longint x, y, z, dx, dy, cc, ss;
      a = ang % 46080;
      q = a / 11520;
      r = a % 11520;
      if (r == 0) begin
         cc = ONE30;
         ss = 0;
      end else begin
         x = GAIN * 4;
         y = 0;
         z = longint'(r) << 9;
         for (int i = 0; i < STEPS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0) begin
               x -= dy; y += dx; z -= atan_step(i);
            end else begin
               x += dy; y -= dx; z += atan_step(i);
            end
         end
         cc = clamp(round_shift(x, 2), -ONE30, ONE30);
         ss = clamp(round_shift(y, 2), -ONE30, ONE30);
      end
      case (q)
         0: begin c = cc;  s = ss;  end
         1: begin c = -ss; s = cc;  end
         2: begin c = -cc; s = -ss; end
         default: begin c = ss; s = -cc; end
      endcase
   endfunction

   // vectoring cordic: atan2 in 1/128 degree, unwrapped
   function automatic longint heading_of(input longint x0, input longint y0);
      longint x, y, z, dx, dy;
      x = x0;
      y = y0;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x; y = -y; z = 180 * 65536;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x += dy; y -= dx; z += atan_step(i);
         end else begin
            x -= dy; y += dx; z -= atan_step(i);
         end
      end
      return round_shift(z, 9);
   endfunction

   function automatic longint int_sqrt(input longint unsigned v0);
      longint unsigned v, res, b;
      v = v0;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic rsp_type predict_orientation(input req_type r);
      rsp_type o;
      longint cs, ss, cd, sd, g, sc, one, nx, ny, nz, hz, dip, dd;
      o = '0;
      if (r.func == 1'(FUNC_VEC)) begin
         rotate_angle(r.strike_in, cs, ss);
         rotate_angle(r.dip_in, cd, sd);
         // vertical plane keeps the positive sign, overturned flips it
         g = (cd < 0) ? -1 : 1;
         o.dip_vec_x    = saturate(round_shift(cs * cd, 60 - FRAC));
         o.dip_vec_y    = saturate(round_shift(-(ss * cd), 60 - FRAC));
         o.dip_vec_z    = saturate(round_shift(-sd, 30 - FRAC));
         o.strike_vec_x = saturate(round_shift(g * ss, 30 - FRAC));
         o.strike_vec_y = saturate(round_shift(g * cs, 30 - FRAC));
         o.normal_x_out = saturate(round_shift(g * (sd * cs), 60 - FRAC));
         o.normal_y_out = saturate(round_shift(-g * (sd * ss), 60 - FRAC));
         o.normal_z_out = saturate(round_shift(g * cd, 30 - FRAC));
         o.strike_out   = r.strike_in;
         o.dip_out      = r.dip_in;
      end else begin
         sc  = 64'sd1 << (30 - FRAC);
         one = 64'sd1 << FRAC;
         nx  = longint'(r.normal_x_in) * sc;
         ny  = longint'(r.normal_y_in) * sc;
         nz  = clamp(longint'(r.normal_z_in), -one, one) * sc;
         hz  = int_sqrt(longint'(ONE30 * ONE30 - nz * nz));
         dip = clamp(heading_of(hz, nz), 0, 23040);
         dd  = heading_of(nx, ny) % 46080;
         if (dd < 0) dd += 46080;
         o.normal_x_out = r.normal_x_in;
         o.normal_y_out = r.normal_y_in;
         o.normal_z_out = r.normal_z_in;
         o.strike_out   = 16'(46080 - dd);
         o.dip_out      = 15'(dip);
      end
      return o;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // mostly short gaps, a few long ones
   function automatic int gap_length();
      if (stall_free) return 0;
      if ($urandom_range(99) < 60) return 0;
      if ($urandom_range(99) < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // drive one item and wait for it to be taken
   task automatic send_orientation(input req_type r);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      expected_orient_q.insert(expected_orient_q.size(), predict_orientation(r));
      @(negedge clock);
   endtask

   task automatic idle_request();
      req_if.valid   <= 1'b0;
      req_if.payload <= $urandom();
   endtask

   function automatic req_type angle_item(input int unsigned s, input int unsigned d);
      req_type r;
      r = '0;
      r.func      = 1'(FUNC_VEC);
      r.strike_in = 16'(s);
      r.dip_in    = 15'(d);
      // unused fields carry noise
      r.normal_x_in = $urandom();
      r.normal_y_in = $urandom();
      r.normal_z_in = $urandom();
      return r;
   endfunction

   function automatic req_type normal_item(input int x, input int y, input int z);
      req_type r;
      r = '0;
      r.func        = 1'(FUNC_ANG);
      r.normal_x_in = 16'(x);
      r.normal_y_in = 16'(y);
      r.normal_z_in = 16'(z);
      r.strike_in   = $urandom();
      r.dip_in      = $urandom();
      return r;
   endfunction

   // result side: random stall, sample at rising edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = 0;
      end else if (stall_free) begin
         rsp_if.ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(99) < rsp_long_stall) begin
         rsp_hold = $urandom_range(10, 60);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) < 70);
      end
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_orient_q.size() == 0) begin
            report_mismatch("unexpected item", 0, 0);
         end else begin
            want = expected_orient_q.pop_front();
            if (got.dip_vec_x !== want.dip_vec_x)
               report_mismatch("dip_vec_x", got.dip_vec_x, want.dip_vec_x);
            if (got.dip_vec_y !== want.dip_vec_y)
               report_mismatch("dip_vec_y", got.dip_vec_y, want.dip_vec_y);
            if (got.dip_vec_z !== want.dip_vec_z)
               report_mismatch("dip_vec_z", got.dip_vec_z, want.dip_vec_z);
            if (got.strike_vec_x !== want.strike_vec_x)
               report_mismatch("strike_vec_x", got.strike_vec_x, want.strike_vec_x);
            if (got.strike_vec_y !== want.strike_vec_y)
               report_mismatch("strike_vec_y", got.strike_vec_y, want.strike_vec_y);
            if (got.strike_vec_z !== want.strike_vec_z)
               report_mismatch("strike_vec_z", got.strike_vec_z, want.strike_vec_z);
            if (got.normal_x_out !== want.normal_x_out)
               report_mismatch("normal_x_out", got.normal_x_out, want.normal_x_out);
            if (got.normal_y_out !== want.normal_y_out)
               report_mismatch("normal_y_out", got.normal_y_out, want.normal_y_out);
            if (got.normal_z_out !== want.normal_z_out)
               report_mismatch("normal_z_out", got.normal_z_out, want.normal_z_out);
            if (got.strike_out !== want.strike_out)
               report_mismatch("strike_out", got.strike_out, want.strike_out);
            if (got.dip_out !== want.dip_out)
               report_mismatch("dip_out", got.dip_out, want.dip_out);
         end
      end
   end

   // angle extremes, quadrant angles, vertical and overturned planes, wrap
   task automatic test_angle_corners();
      int unsigned strikes [8] = '{0, 1, 11520, 23040, 34560, 46079, 46080, 65535};
      int unsigned dips [7] = '{0, 1, 11520, 11521, 23040, 32767, 12345};
      foreach (strikes[i]) send_orientation(angle_item(strikes[i], dips[i % 7]));
      foreach (dips[i]) send_orientation(angle_item(5000, dips[i]));
   endtask

   // zero horizontal normal, nz beyond unit, axis directions, extremes
   task automatic test_normal_corners();
      send_orientation(normal_item(0, 0, 16384));
      send_orientation(normal_item(0, 0, 32767));
      send_orientation(normal_item(0, 0, -32768));
      send_orientation(normal_item(16384, 0, 0));
      send_orientation(normal_item(-16384, 0, 0));
      send_orientation(normal_item(0, 16384, -16384));
      send_orientation(normal_item(0, -16384, 100));
      send_orientation(normal_item(32767, -32768, 0));
      send_orientation(normal_item(-32768, 32767, -1));
   endtask

   task automatic test_random_angles(input int count);
      int unsigned s, d;
      repeat (count) begin
         case ($urandom_range(3))
            0: begin s = $urandom_range(65535); d = $urandom_range(32767); end
            1: begin s = 11520 * $urandom_range(4) + $urandom_range(2) - 1;
                     d = 11520 * $urandom_range(2) + $urandom_range(2) - 1; end
            default: begin s = $urandom_range(46080); d = $urandom_range(23040); end
         endcase
         send_orientation(angle_item(s & 16'hffff, d & 15'h7fff));
      end
   endtask

   task automatic test_random_normals(input int count);
      int x, y, z;
      repeat (count) begin
         if ($urandom_range(3) == 0) begin
            x = $signed(16'($urandom()));
            y = $signed(16'($urandom()));
            z = $signed(16'($urandom()));
         end else begin
            x = int'($urandom_range(32768)) - 16384;
            y = int'($urandom_range(32768)) - 16384;
            z = int'($urandom_range(32768)) - 16384;
            if ($urandom_range(9) == 0) begin
               x = 0; y = 0;
            end
         end
         send_orientation(normal_item(x, y, z));
      end
   endtask

   // back to back with no stall anywhere
   task automatic test_full_rate(input int count);
      stall_free = 1'b1;
      test_random_angles(count / 2);
      test_random_normals(count / 2);
      stall_free = 1'b0;
   endtask

   task automatic drain_results();
      idle_request();
      wait (expected_orient_q.size() == 0);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   initial begin
      mismatch_count = 0;
      rsp_long_stall = 2;
      rsp_hold       = 0;
      stall_free     = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_angle_corners();
      test_normal_corners();
      test_random_angles(600);
      test_random_normals(600);
      test_full_rate(300);
      rsp_long_stall = 10;
      test_random_angles(50);
      test_random_normals(50);

      drain_results();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- strike_dip_normal_conversion_unit.f -----
hdl/sdnc_pkg.sv
hdl/sdnc_if.sv
hdl/sdnc_sqrt_cell.sv
hdl/sdnc_cordic_cell.sv
hdl/strike_dip_normal_conversion_unit.sv
tb/strike_dip_normal_conversion_unit_test.sv
